// ===== design/assert_macros.svh =====
// assertion macros included by the executor rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define AST_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/trie_pkg.sv =====
// package: field widths, opcodes and default sizes of the instruction executor
`default_nettype none

package trie_pkg;

	localparam int ACT_W     = 4;
	localparam int REG_IDX_W = 10;
	localparam int VAR_IDX_W = 3;
	localparam int IMM_W     = 32;
	localparam int OUT_VAL_W = 32;

	localparam int DEF_REG_COUNT  = 1024;
	localparam int DEF_VAR_COUNT  = 6;
	localparam int DEF_DATA_WIDTH = 32;

	typedef enum logic [ACT_W-1:0] {
		OP_LOAD  = 4'd0,
		OP_LOADI = 4'd1,
		OP_STORE = 4'd2,
		OP_ADD   = 4'd3,
		OP_SUB   = 4'd4,
		OP_MUL   = 4'd5,
		OP_AND   = 4'd6,
		OP_OR    = 4'd7,
		OP_READ  = 4'd8,
		OP_WRITE = 4'd9
	} op_t;

endpackage

`default_nettype wire

// ===== design/tiny_risc_instruction_executor.sv =====
// top level: register machine that executes one instruction per input beat
`default_nettype none

// One instruction is accepted every cycle unless the output side stalls, and its result beat
// passes through the stage register and then the output register. Acceptance reads
// both source registers from the register file (one write port, two registered read
// ports) into the stage register; when the stage advances, the alu or variable access runs,
// writes the register file and the variable set, and loads the output register. A
// register written by the instruction just ahead is forwarded from that write, so
// dependent instructions still issue back to back. The variables reset to zero; the
// register file has no reset and must be written before it is read.
module tiny_risc_instruction_executor
	import trie_pkg::*;
#(
	parameter int REG_COUNT  = DEF_REG_COUNT,
	parameter int VAR_COUNT  = DEF_VAR_COUNT,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [ACT_W-1:0]            action,
	input  wire logic [REG_IDX_W-1:0]        target_reg,
	input  wire logic [REG_IDX_W-1:0]        first_reg,
	input  wire logic [REG_IDX_W-1:0]        second_reg,
	input  wire logic [VAR_IDX_W-1:0]        variable,
	input  wire logic signed [IMM_W-1:0]     immediate,
	input  wire logic signed [IMM_W-1:0]     read_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             write_valid,
	output logic [VAR_IDX_W-1:0]             out_variable,
	output logic signed [OUT_VAL_W-1:0]      out_value,
	output logic                             illegal
);

`include "assert_macros.svh"

	localparam int RIDX = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int RW   = (RIDX > REG_IDX_W) ? RIDX : REG_IDX_W;
	localparam int VIDX = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
	localparam int VW   = (VIDX > VAR_IDX_W) ? VIDX : VAR_IDX_W;

	logic                  accept;
	logic                  advance;

	logic [RW-1:0]         ra_w;
	logic [RW-1:0]         rb_w;
	logic [RW-1:0]         rd_w;
	logic [RIDX-1:0]       ra_idx;
	logic [RIDX-1:0]       rb_idx;

	logic [DATA_WIDTH-1:0] mem [REG_COUNT];

	logic                  s1_v_q;
	logic [ACT_W-1:0]      act_s1;
	logic [RIDX-1:0]       rd_idx_s1;
	logic                  rd_ok_s1;
	logic                  ra_ok_s1;
	logic                  rb_ok_s1;
	logic [VAR_IDX_W-1:0]  var_s1;
	logic signed [IMM_W-1:0] imm_s1;
	logic signed [IMM_W-1:0] rv_s1;
	logic [DATA_WIDTH-1:0] mem_a_s1;
	logic [DATA_WIDTH-1:0] mem_b_s1;
	logic                  fwd_a_s1;
	logic                  fwd_b_s1;
	logic [DATA_WIDTH-1:0] byp_s1;

	logic [DATA_WIDTH-1:0] vars_q [VAR_COUNT];

	logic [VW-1:0]         var_w;
	logic [VIDX-1:0]       var_idx;
	logic                  var_ok;
	logic [DATA_WIDTH-1:0] opa;
	logic [DATA_WIDTH-1:0] opb;
	logic [DATA_WIDTH-1:0] var_rd;
	logic [DATA_WIDTH-1:0] prod;
	logic                  reg_wr;
	logic                  reg_we;
	logic [DATA_WIDTH-1:0] reg_wd;
	logic                  var_wr;
	logic                  var_we;
	logic [DATA_WIDTH-1:0] var_wd;
	logic                  wr_flag;
	logic                  ill_flag;

	logic                  out_valid_q;
	logic                  write_valid_q;
	logic [VAR_IDX_W-1:0]  out_variable_q;
	logic [OUT_VAL_W-1:0]  out_value_q;
	logic                  illegal_q;

	// handshake
	assign advance  = s1_v_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_v_q && !advance;
	assign accept   = in_valid && !in_stall;

	// source indexes at the input
	assign ra_w   = RW'(first_reg);
	assign rb_w   = RW'(second_reg);
	assign rd_w   = RW'(target_reg);
	assign ra_idx = ra_w[RIDX-1:0];
	assign rb_idx = rb_w[RIDX-1:0];

	// register file: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (reg_we) begin
			mem[rd_idx_s1] <= reg_wd;
		end
		if (accept) begin
			mem_a_s1 <= mem[ra_idx];
			mem_b_s1 <= mem[rb_idx];
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= action;
			rd_idx_s1 <= rd_w[RIDX-1:0];
			rd_ok_s1  <= 32'(target_reg) < REG_COUNT;
			ra_ok_s1  <= 32'(first_reg) < REG_COUNT;
			rb_ok_s1  <= 32'(second_reg) < REG_COUNT;
			var_s1    <= variable;
			imm_s1    <= immediate;
			rv_s1     <= read_value;
			fwd_a_s1  <= reg_we && (rd_idx_s1 == ra_idx);
			fwd_b_s1  <= reg_we && (rd_idx_s1 == rb_idx);
			byp_s1    <= reg_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (advance) begin
			s1_v_q <= 1'b0;
		end
	end

	// execute
	assign var_w   = VW'(var_s1);
	assign var_idx = var_w[VIDX-1:0];
	assign var_ok  = 32'(var_s1) < VAR_COUNT;
	assign var_rd  = var_ok ? vars_q[var_idx] : '0;
	assign opa     = !ra_ok_s1 ? '0 : (fwd_a_s1 ? byp_s1 : mem_a_s1);
	assign opb     = !rb_ok_s1 ? '0 : (fwd_b_s1 ? byp_s1 : mem_b_s1);
	assign prod    = opa * opb;

	always_comb begin
		reg_wr   = 1'b0;
		reg_wd   = '0;
		var_wr   = 1'b0;
		var_wd   = '0;
		wr_flag  = 1'b0;
		ill_flag = 1'b0;
		case (op_t'(act_s1))
			OP_LOAD: begin
				reg_wr = 1'b1;
				reg_wd = var_rd;
			end
			OP_LOADI: begin
				reg_wr = 1'b1;
				reg_wd = DATA_WIDTH'(imm_s1);
			end
			OP_STORE: begin
				var_wr = 1'b1;
				var_wd = opa;
			end
			OP_ADD: begin
				reg_wr = 1'b1;
				reg_wd = opa + opb;
			end
			OP_SUB: begin
				reg_wr = 1'b1;
				reg_wd = opa - opb;
			end
			OP_MUL: begin
				reg_wr = 1'b1;
				reg_wd = prod;
			end
			OP_AND: begin
				reg_wr = 1'b1;
				reg_wd = opa & opb;
			end
			OP_OR: begin
				reg_wr = 1'b1;
				reg_wd = opa | opb;
			end
			OP_READ: begin
				var_wr = 1'b1;
				var_wd = DATA_WIDTH'(rv_s1);
			end
			OP_WRITE: begin
				wr_flag = 1'b1;
			end
			default: begin
				ill_flag = 1'b1;
			end
		endcase
	end

	assign reg_we = advance && reg_wr && rd_ok_s1;
	assign var_we = advance && var_wr && var_ok;

	// variables a to f
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VAR_COUNT; i++) begin
				vars_q[i] <= '0;
			end
		end else if (var_we) begin
			vars_q[var_idx] <= var_wd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			write_valid_q  <= wr_flag;
			out_variable_q <= wr_flag ? var_s1 : '0;
			out_value_q    <= wr_flag ? OUT_VAL_W'(var_rd) : '0;
			illegal_q      <= ill_flag;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_valid  = write_valid_q;
	assign out_variable = out_variable_q;
	assign out_value    = out_value_q;
	assign illegal      = illegal_q;

	`AST_NEXT(a_accept_fills_stage, accept, s1_v_q, "accepted beat did not reach stage one")
	`AST_NEXT(a_advance_fills_out, advance, out_valid_q, "executed beat did not reach output")
	`AST_NOW(a_flags_exclusive, out_valid_q, !(write_valid_q && illegal_q), "write and illegal both set")
	`AST_NOW(a_quiet_value, out_valid_q && !write_valid_q, out_value_q == '0, "value on a non-write beat")

endmodule

`default_nettype wire

// ===== tb/tb_tiny_risc_instruction_executor.sv =====
// testbench: directed and random instruction streams checked against a register machine predictor
`timescale 1ns / 1ps

module tb_tiny_risc_instruction_executor;
	import trie_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 120;
	localparam logic [ACT_W-1:0] OP_ILLEGAL_FIRST = ACT_W'(OP_WRITE + 1);
	localparam logic [ACT_W-1:0] OP_ILLEGAL_LAST  = {ACT_W{1'b1}};
	localparam logic [31:0] VAL_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [31:0] VAL_ONES = 32'hffff_ffff;

	typedef struct {
		logic [ACT_W-1:0]     action;
		logic [REG_IDX_W-1:0] target_reg;
		logic [REG_IDX_W-1:0] first_reg;
		logic [REG_IDX_W-1:0] second_reg;
		logic [VAR_IDX_W-1:0] variable;
		logic [IMM_W-1:0]     immediate;
		logic [IMM_W-1:0]     read_value;
	} instr_t;

	typedef struct {
		logic                 write_valid;
		logic [VAR_IDX_W-1:0] out_variable;
		logic [OUT_VAL_W-1:0] out_value;
		logic                 illegal;
	} result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [ACT_W-1:0]            action = '0;
	logic [REG_IDX_W-1:0]        target_reg = '0;
	logic [REG_IDX_W-1:0]        first_reg = '0;
	logic [REG_IDX_W-1:0]        second_reg = '0;
	logic [VAR_IDX_W-1:0]        variable = '0;
	logic signed [IMM_W-1:0]     immediate = '0;
	logic signed [IMM_W-1:0]     read_value = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        write_valid;
	logic [VAR_IDX_W-1:0]        out_variable;
	logic signed [OUT_VAL_W-1:0] out_value;
	logic                        illegal;

	logic [DEF_DATA_WIDTH-1:0] reg_shadow [DEF_REG_COUNT];
	logic [DEF_DATA_WIDTH-1:0] var_shadow [DEF_VAR_COUNT];
	bit                        reg_written [DEF_REG_COUNT];
	int                        written_regs [$];
	int                        last_rd = 0;

	result_t expected_results [$];
	int      failures = 0;
	int      stuck_cycles = 0;
	int      src_idle_pct = 0;
	int      sink_stall_pct = 0;

	tiny_risc_instruction_executor uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.target_reg   (target_reg),
		.first_reg    (first_reg),
		.second_reg   (second_reg),
		.variable     (variable),
		.immediate    (immediate),
		.read_value   (read_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_valid  (write_valid),
		.out_variable (out_variable),
		.out_value    (out_value),
		.illegal      (illegal)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void put_reg(input int rd, input logic [DEF_DATA_WIDTH-1:0] v);
		reg_shadow[rd] = v;
		if (!reg_written[rd]) begin
			reg_written[rd] = 1'b1;
			written_regs.push_back(rd);
		end
		last_rd = rd;
	endfunction

	function automatic void put_var(input int vi, input logic [DEF_DATA_WIDTH-1:0] v);
		if (vi < DEF_VAR_COUNT)
			var_shadow[vi] = v;
	endfunction

	function automatic logic [DEF_DATA_WIDTH-1:0] get_var(input int vi);
		return (vi < DEF_VAR_COUNT) ? var_shadow[vi] : '0;
	endfunction

	function automatic result_t run_instruction(input instr_t ins);
		result_t                   res;
		logic [DEF_DATA_WIDTH-1:0] a;
		logic [DEF_DATA_WIDTH-1:0] b;
		int                        rd;
		int                        vi;
		res = '{write_valid: 1'b0, out_variable: '0, out_value: '0, illegal: 1'b0};
		a = reg_shadow[ins.first_reg];
		b = reg_shadow[ins.second_reg];
		rd = int'(ins.target_reg);
		vi = int'(ins.variable);
		case (ins.action)
			OP_LOAD:  put_reg(rd, get_var(vi));
			OP_LOADI: put_reg(rd, ins.immediate);
			OP_STORE: put_var(vi, a);
			OP_ADD:   put_reg(rd, a + b);
			OP_SUB:   put_reg(rd, a - b);
			OP_MUL:   put_reg(rd, a * b);
			OP_AND:   put_reg(rd, a & b);
			OP_OR:    put_reg(rd, a | b);
			OP_READ:  put_var(vi, ins.read_value);
			OP_WRITE: begin
				res.write_valid  = 1'b1;
				res.out_variable = ins.variable;
				res.out_value    = get_var(vi);
			end
			default:  res.illegal = 1'b1;
		endcase
		return res;
	endfunction

	function automatic int pick_source();
		if (written_regs.size() == 0)
			return $urandom_range(DEF_REG_COUNT - 1);
		if ($urandom_range(99) < 30)
			return last_rd;
		return written_regs[$urandom_range(written_regs.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return VAL_ONES;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t pick_instr();
		instr_t ins;
		int     r;
		r = $urandom_range(99);
		if (r < 12)
			ins.action = OP_LOADI;
		else if (r < 22)
			ins.action = OP_LOAD;
		else if (r < 32)
			ins.action = OP_STORE;
		else if (r < 67)
			ins.action = ACT_W'(OP_ADD + $urandom_range(OP_OR - OP_ADD));
		else if (r < 77)
			ins.action = OP_READ;
		else if (r < 93)
			ins.action = OP_WRITE;
		else
			ins.action = ACT_W'(OP_ILLEGAL_FIRST
				+ $urandom_range(OP_ILLEGAL_LAST - OP_ILLEGAL_FIRST));
		ins.target_reg = ($urandom_range(99) < 40) ? REG_IDX_W'($urandom_range(15))
			: REG_IDX_W'($urandom_range(DEF_REG_COUNT - 1));
		ins.first_reg  = REG_IDX_W'(pick_source());
		ins.second_reg = REG_IDX_W'(pick_source());
		ins.variable   = ($urandom_range(99) < 85) ? VAR_IDX_W'($urandom_range(DEF_VAR_COUNT - 1))
			: VAR_IDX_W'($urandom_range((1 << VAR_IDX_W) - 1));
		ins.immediate  = pick_value();
		ins.read_value = pick_value();
		return ins;
	endfunction

	task automatic send_instr(input instr_t ins);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= ins.action;
		target_reg <= ins.target_reg;
		first_reg  <= ins.first_reg;
		second_reg <= ins.second_reg;
		variable   <= ins.variable;
		immediate  <= ins.immediate;
		read_value <= ins.read_value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(run_instruction(ins));
	endtask

	task automatic issue(input logic [ACT_W-1:0] op, input int rd, input int ra, input int rb,
			input int vi, input logic [31:0] value);
		instr_t ins;
		ins = '{action: op, target_reg: REG_IDX_W'(rd), first_reg: REG_IDX_W'(ra),
			second_reg: REG_IDX_W'(rb), variable: VAR_IDX_W'(vi),
			immediate: value, read_value: value};
		send_instr(ins);
	endtask

	task automatic report_failure(input string why);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%s", why);
	endtask

	task automatic test_arithmetic_extremes();
		issue(OP_LOADI, 0, 0, 0, 0, VAL_MAX);
		issue(OP_LOADI, 1023, 0, 0, 7, VAL_MIN);
		issue(OP_LOADI, 1, 0, 1023, 0, VAL_ONES);
		issue(OP_LOADI, 2, 1023, 1, 0, '0);
		issue(OP_ADD, 3, 0, 0, 0, '0);
		issue(OP_SUB, 4, 2, 1023, 0, '0);
		issue(OP_MUL, 5, 1023, 1, 0, '0);
		issue(OP_MUL, 6, 0, 0, 0, '0);
		issue(OP_AND, 7, 1, 1023, 0, '0);
		issue(OP_OR, 8, 2, 0, 0, '0);
		issue(OP_ADD, 9, 8, 7, 0, '0);
	endtask

	task automatic test_variable_access();
		issue(OP_READ, 0, 0, 0, 0, VAL_MIN);
		issue(OP_READ, 0, 0, 0, DEF_VAR_COUNT - 1, VAL_MAX);
		issue(OP_READ, 0, 0, 0, 6, VAL_ONES);
		issue(OP_WRITE, 0, 0, 0, 0, '0);
		issue(OP_WRITE, 0, 0, 0, DEF_VAR_COUNT - 1, '0);
		issue(OP_WRITE, 0, 0, 0, 7, '0);
		issue(OP_STORE, 0, 1023, 0, 1, '0);
		issue(OP_STORE, 0, 0, 0, 7, '0);
		issue(OP_LOAD, 10, 0, 0, 1, '0);
		issue(OP_STORE, 0, 10, 10, 2, '0);
		issue(OP_LOAD, 11, 10, 10, 6, '0);
		issue(OP_WRITE, 0, 11, 10, 2, '0);
	endtask

	task automatic test_illegal_opcodes();
		for (int op = int'(OP_ILLEGAL_FIRST); op <= int'(OP_ILLEGAL_LAST); op++)
			issue(ACT_W'(op), $urandom_range(DEF_REG_COUNT - 1), 3, 4, 1, $urandom);
		issue(OP_WRITE, 0, 3, 4, 1, '0);
	endtask

	task automatic random_program(input int count);
		repeat (count)
			send_instr(pick_instr());
	endtask

	task automatic test_random_no_idle();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		random_program(PHASE_ITEMS);
	endtask

	task automatic test_random_sender_idle();
		src_idle_pct   = 71;
		sink_stall_pct = 0;
		random_program(PHASE_ITEMS);
	endtask

	task automatic test_random_receiver_stall();
		src_idle_pct   = 0;
		sink_stall_pct = 71;
		random_program(PHASE_ITEMS);
	endtask

	task automatic test_random_both_idle();
		src_idle_pct   = 29;
		sink_stall_pct = 29;
		random_program(PHASE_ITEMS);
	endtask

	always @(posedge clk) begin : check_results
		result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_failure($sformatf("unexpected result beat: wv=%0b var=%0d val=%h ill=%0b",
					write_valid, out_variable, out_value, illegal));
			end else begin
				exp = expected_results.pop_front();
				if (write_valid !== exp.write_valid || out_variable !== exp.out_variable
						|| out_value !== exp.out_value || illegal !== exp.illegal)
					report_failure($sformatf(
						"mismatch: expected wv=%0b var=%0d val=%h ill=%0b, got wv=%0b var=%0d val=%h ill=%0b",
						exp.write_valid, exp.out_variable, exp.out_value, exp.illegal,
						write_valid, out_variable, out_value, illegal));
			end
		end
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		foreach (reg_shadow[i]) begin
			reg_shadow[i]  = '0;
			reg_written[i] = 1'b0;
		end
		foreach (var_shadow[i])
			var_shadow[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arithmetic_extremes();
		test_variable_access();
		test_illegal_opcodes();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== tiny_risc_instruction_executor.f =====
+incdir+design
design/trie_pkg.sv
design/tiny_risc_instruction_executor.sv
tb/tb_tiny_risc_instruction_executor.sv
